// ===== hdl/generational_handle_pool_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the generational handle pool
// Shared property forms so every assertion in the project reads the same way.
// ----------------------------------------------------------------------------
`ifndef GENERATIONAL_HANDLE_POOL_DEFINES_SVH
`define GENERATIONAL_HANDLE_POOL_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define GHP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define GHP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ghp_pkg.sv =====
// ----------------------------------------------------------------------------
// ghp_pkg
// Types and constants shared by the generational handle pool modules.
// ----------------------------------------------------------------------------
package ghp_pkg;

  // Table geometry.
  localparam int SLOTS  = 1024;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int GEN_W  = 8;
  localparam int GEN_MAX = 255;
  localparam int COUNT_W = 32;

  // Stream widths.
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 88;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 2;

  // Operation codes carried on the input tuser.
  typedef enum logic [OP_W-1:0] {
    OP_ACQUIRE = 2'd0,
    OP_RELEASE = 2'd1,
    OP_LOOKUP  = 2'd2
  } op_t;

  // Result status codes carried on the output tuser.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  // Control sequence for one item.
  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EXEC
  } state_t;

  // One entry of the slot memory.
  typedef struct packed {
    logic [GEN_W-1:0]   gen;
    logic               alive;
    logic [COUNT_W-1:0] vertices;
    logic [COUNT_W-1:0] indices;
  } slot_t;

  localparam int SLOT_ENTRY_W = $bits(slot_t);

endpackage

// ===== hdl/ghp_ram.sv =====
// ----------------------------------------------------------------------------
// ghp_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ghp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/generational_handle_pool.sv =====
// ----------------------------------------------------------------------------
// generational_handle_pool
// Handle table with generation counters, a LIFO free list and count storage.
// ----------------------------------------------------------------------------
// An item selects acquire, release or lookup on s_tuser. It passes through
// the read and exec steps before its result lands in the output register.
// The accepting edge launches the read of the free-stack top and the addressed
// slot. The read step reads the popped slot (acquire from the free list). The
// exec step checks the handle and writes back the slot and stack. The two
// dependent memory reads of an acquire call for the separate read step. The
// input side is ready again in the cycle after the result is loaded, so no new
// item is taken before the last one is through. The result register frees the
// input side, so a new item is taken while a result still waits on the master
// side; the block holds in its final step only while that register is still
// occupied. There is no clearing pass after reset: slot entries are used only
// for slots that have been handed out.
`include "generational_handle_pool_defines.svh"

module generational_handle_pool (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // Fields from bit 0: slot_index[9:0], handle_gen[17:10],
  // vertex_count[49:18], index_count[81:50], zero fill[87:82].
  input  logic [ghp_pkg::IN_DATA_W-1:0]     s_tdata,
  // Fields from bit 0: op[1:0].
  input  logic [ghp_pkg::OP_W-1:0]          s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // Fields from bit 0: out_slot[9:0], out_gen[17:10],
  // out_vertices[49:18], out_indices[81:50], zero fill[87:82].
  output logic [ghp_pkg::OUT_DATA_W-1:0]    m_tdata,
  // Fields from bit 0: status[1:0].
  output logic [ghp_pkg::STATUS_W-1:0]      m_tuser
);

  localparam int SW = ghp_pkg::SLOT_W;
  localparam int CW = ghp_pkg::CNT_W;
  localparam int GW = ghp_pkg::GEN_W;
  localparam int NW = ghp_pkg::COUNT_W;

  // Control state.
  ghp_pkg::state_t state, state_next;
  logic [CW-1:0] used_slots, used_slots_next;
  logic [CW-1:0] free_top, free_top_next;

  // Captured item.
  ghp_pkg::op_t  op_q;
  logic [SW-1:0] idx_q;
  logic [GW-1:0] gen_q;
  logic [NW-1:0] vc_q;
  logic [NW-1:0] ic_q;
  logic [SW-1:0] pop_slot;
  logic          pop_capture;

  // Memory ports.
  logic                  slot_we, slot_re;
  logic [SW-1:0]         slot_waddr, slot_raddr;
  ghp_pkg::slot_t        slot_wdata, slot_rdata;
  logic [ghp_pkg::SLOT_ENTRY_W-1:0] slot_rbits;
  logic                  stk_we, stk_re;
  logic [SW-1:0]         stk_waddr, stk_raddr, stk_wdata, stk_rdata;

  // Result.
  logic                     out_load;
  ghp_pkg::status_t         res_status;
  logic [SW-1:0]            res_slot;
  logic [GW-1:0]            res_gen;
  logic [NW-1:0]            res_vert;
  logic [NW-1:0]            res_ind;

  // Handle check and generation advance.
  logic          handle_ok;
  logic          counts_zero;
  logic [GW-1:0] gen_mod;
  logic [GW-1:0] gen_bump;

  assign slot_rdata = ghp_pkg::slot_t'(slot_rbits);

  // Slot memory: generation, alive flag and both counts.
  ghp_ram #(
    .WIDTH (ghp_pkg::SLOT_ENTRY_W),
    .DEPTH (ghp_pkg::SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (slot_re),
    .raddr (slot_raddr),
    .rdata (slot_rbits)
  );

  // Free stack of released slots.
  ghp_ram #(
    .WIDTH (SW),
    .DEPTH (ghp_pkg::SLOTS)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // Handle is valid when non-null, handed out, alive and of matching generation.
  assign handle_ok = (gen_q != '0) && ({1'b0, idx_q} < used_slots) &&
                     slot_rdata.alive && (slot_rdata.gen == gen_q);
  assign counts_zero = (vc_q == '0) || (ic_q == '0);

  // Next generation is (g mod GEN_MAX) + 1; g never reaches twice GEN_MAX.
  assign gen_mod  = (slot_rdata.gen >= GW'(ghp_pkg::GEN_MAX)) ?
                    slot_rdata.gen - GW'(ghp_pkg::GEN_MAX) : slot_rdata.gen;
  assign gen_bump = gen_mod + GW'(1);

  // State register and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ghp_pkg::S_IDLE;
      used_slots <= '0;
      free_top   <= '0;
    end else begin
      state      <= state_next;
      used_slots <= used_slots_next;
      free_top   <= free_top_next;
    end
  end

  // Capture the item on acceptance and the popped slot after the stack read.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op_q  <= ghp_pkg::op_t'(s_tuser);
      idx_q <= s_tdata[SW-1:0];
      gen_q <= s_tdata[SW +: GW];
      vc_q  <= s_tdata[SW+GW +: NW];
      ic_q  <= s_tdata[SW+GW+NW +: NW];
    end
    if (pop_capture) begin
      pop_slot <= stk_rdata;
    end
  end

  // Sequencing, memory accesses and result formation.
  always_comb begin
    state_next      = state;
    used_slots_next = used_slots;
    free_top_next   = free_top;
    s_tready        = 1'b0;
    pop_capture     = 1'b0;
    slot_re         = 1'b0;
    slot_raddr      = idx_q;
    slot_we         = 1'b0;
    slot_waddr      = idx_q;
    slot_wdata      = '0;
    stk_re          = 1'b0;
    stk_raddr       = free_top[SW-1:0] - SW'(1);
    stk_we          = 1'b0;
    stk_waddr       = free_top[SW-1:0];
    stk_wdata       = idx_q;
    out_load        = 1'b0;
    res_status      = ghp_pkg::ST_INVALID;
    res_slot        = idx_q;
    res_gen         = '0;
    res_vert        = '0;
    res_ind         = '0;

    unique case (state)
      ghp_pkg::S_IDLE: begin
        // Read the addressed slot and the stack top as the item arrives.
        s_tready   = 1'b1;
        slot_raddr = s_tdata[SW-1:0];
        if (s_tvalid) begin
          slot_re    = 1'b1;
          stk_re     = 1'b1;
          state_next = ghp_pkg::S_READ;
        end
      end

      ghp_pkg::S_READ: begin
        // An acquire from the free list reads the popped slot's generation.
        if ((op_q == ghp_pkg::OP_ACQUIRE) && (free_top != '0)) begin
          slot_re     = 1'b1;
          slot_raddr  = stk_rdata;
          pop_capture = 1'b1;
        end
        state_next = ghp_pkg::S_EXEC;
      end

      ghp_pkg::S_EXEC: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ghp_pkg::S_IDLE;
          case (op_q)
            ghp_pkg::OP_ACQUIRE: begin
              priority if (counts_zero) begin
                res_status = ghp_pkg::ST_EMPTY;
              end else if (free_top != '0) begin
                // Reuse the most recently released slot.
                free_top_next    = free_top - CW'(1);
                slot_we          = 1'b1;
                slot_waddr       = pop_slot;
                slot_wdata.gen   = (slot_rdata.gen == '0) ? GW'(1) : slot_rdata.gen;
                slot_wdata.alive = 1'b1;
                slot_wdata.vertices = vc_q;
                slot_wdata.indices  = ic_q;
                res_status = ghp_pkg::ST_OK;
                res_slot   = pop_slot;
                res_gen    = slot_wdata.gen;
              end else if (used_slots < CW'(ghp_pkg::SLOTS)) begin
                // Hand out a fresh slot at generation one.
                used_slots_next  = used_slots + CW'(1);
                slot_we          = 1'b1;
                slot_waddr       = used_slots[SW-1:0];
                slot_wdata.gen   = GW'(1);
                slot_wdata.alive = 1'b1;
                slot_wdata.vertices = vc_q;
                slot_wdata.indices  = ic_q;
                res_status = ghp_pkg::ST_OK;
                res_slot   = used_slots[SW-1:0];
                res_gen    = GW'(1);
              end else begin
                res_status = ghp_pkg::ST_FULL;
              end
            end

            ghp_pkg::OP_RELEASE: begin
              if (handle_ok) begin
                // Retire the slot under a new generation and push it.
                slot_we          = 1'b1;
                slot_wdata.gen   = gen_bump;
                slot_wdata.alive = 1'b0;
                if (free_top < CW'(ghp_pkg::SLOTS)) begin
                  stk_we        = 1'b1;
                  free_top_next = free_top + CW'(1);
                end
                res_status = ghp_pkg::ST_OK;
              end
            end

            ghp_pkg::OP_LOOKUP: begin
              if (handle_ok) begin
                res_status = ghp_pkg::ST_OK;
                res_vert   = slot_rdata.vertices;
                res_ind    = slot_rdata.indices;
              end
            end

            default: begin
              // The unused op code is rejected without side effects.
              res_status = ghp_pkg::ST_INVALID;
            end
          endcase
        end
      end

      default: begin
        state_next = ghp_pkg::S_IDLE;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tuser <= res_status;
      m_tdata <= {(ghp_pkg::OUT_DATA_W - SW - GW - 2*NW)'(0),
                  res_ind, res_vert, res_gen, res_slot};
    end
  end

  // The stack never holds more slots than have been handed out.
  `GHP_ASSERT_NOW(a_stack_within_used, 1'b1, free_top <= used_slots, "free stack exceeds used slots")
  // Slots handed out never exceed the table size.
  `GHP_ASSERT_NOW(a_used_bound, 1'b1, used_slots <= CW'(ghp_pkg::SLOTS), "used slots beyond table")
  // An accepted item always proceeds to the read step.
  `GHP_ASSERT_NEXT(a_accept_to_read, s_tvalid && s_tready, state == ghp_pkg::S_READ, "accept did not start read")
  // A full report only occurs with no free slot and the table exhausted.
  `GHP_ASSERT_NOW(a_full_is_real, out_load && (res_status == ghp_pkg::ST_FULL), (free_top == '0) && (used_slots == CW'(ghp_pkg::SLOTS)), "pool full reported with room left")
  // A successful acquire never grants the null generation.
  `GHP_ASSERT_NOW(a_grant_nonnull, out_load && (op_q == ghp_pkg::OP_ACQUIRE) && (res_status == ghp_pkg::ST_OK), res_gen != '0, "acquire granted null generation")

endmodule
